>>> hdl/mi_pkg.sv
// Shared types and constants for the modular inverse core.
`timescale 1ns / 1ps
package mi_pkg;

  localparam int FIELD_BITS = 63;

  typedef struct packed {
    logic busy;
    logic done;
  } mi_div_status_t;

endpackage

>>> hdl/mi_operand_if.sv
// Operand channel: value and modulus with valid/ready handshake.
`timescale 1ns / 1ps
interface mi_operand_if import mi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] value;
  logic [FIELD_BITS-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink (input valid, input value, input modulus, output ready);
endinterface

>>> hdl/mi_result_if.sv
// Result channel: inverse and coprimality flag with valid/ready handshake.
`timescale 1ns / 1ps
interface mi_result_if import mi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] inverse;
  logic                  not_coprime;

  modport source (output valid, output inverse, output not_coprime, input ready);
  modport sink (input valid, input inverse, input not_coprime, output ready);
endinterface

>>> hdl/mi_div_unit.sv
// Bit-serial divider with fused quotient-times-multiplicand accumulation.
`timescale 1ns / 1ps
module mi_div_unit import mi_pkg::*; #(
  parameter int W = 63
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   dividend,
  input  logic [W-1:0]   divisor,
  input  logic [W-1:0]   mult,
  output mi_div_status_t status,
  output logic [W-1:0]   remainder,
  output logic [W-1:0]   product
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  dvd;
  logic [W-1:0]  acc;
  logic [W-1:0]  dsr;
  logic [W-1:0]  mul;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;
  logic [W:0]    acc_next;

  assign trial    = {rem, dvd[W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign ge       = trial >= {1'b0, dsr};
  assign acc_next = {acc, 1'b0} + (ge ? {1'b0, mul} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      acc <= '0;
      dsr <= divisor;
      mul <= mult;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : trial[W-1:0];
      dvd <= {dvd[W-2:0], 1'b0};
      acc <= acc_next[W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign remainder   = rem;
  assign product     = acc;

endmodule

>>> hdl/modular_inverse_core.sv
// Modular inverse by extended Euclid: sequencer around a bit-serial divider.
//
// Usage: present value and modulus on the operands channel; one result beat
// follows on the result channel for every operand beat accepted. Both
// operands are taken in their low OPERAND_BITS bits. The result carries the
// inverse in the range 0 to modulus-1, or 0 with not_coprime set when the
// gcd of the operands is not 1 (modulus zero included).
// Sequence: the operand is first reduced by the modulus, then each Euclid
// step runs one pass of the shared divider, followed by the sequencer states
// S_NEXT and S_CHECK; after the last step come S_FIX, S_NEG and S_OUT, or
// S_OUT alone when not coprime. The divider forms one quotient bit per cycle.
// Throughput: one item at a time; operands.ready is high only while the
// sequencer is idle. The finished result sits in an output register, so the
// next item is accepted while a result waits to be taken.
// Reset: rst (synchronous, active high) clears the sequencer and the output
// valid. A stalled receiver holds the result beat stable; a second finished
// item waits in the sequencer until the output register frees.
`timescale 1ns / 1ps
module modular_inverse_core import mi_pkg::*; #(
  parameter int OPERAND_BITS = 63
) (
  input  logic         clk,
  input  logic         rst,
  mi_operand_if.sink   operands,
  mi_result_if.source  result
);

  localparam int W = OPERAND_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RUN   = 7'b0000010,
    S_NEXT  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_FIX   = 7'b0010000,
    S_NEG   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t         state;
  logic [W-1:0]   m;
  logic [W-1:0]   r0;
  logic [W-1:0]   r1;
  logic [W-1:0]   u0;
  logic [W-1:0]   u1;
  logic [W-1:0]   x;
  logic           parity;
  logic           first;
  logic           flag;

  logic           out_valid;
  logic [W-1:0]   out_inverse;
  logic           out_not_coprime;

  logic [W-1:0]   in_value;
  logic [W-1:0]   in_modulus;
  logic           accept;
  logic           start;
  logic [W-1:0]   div_dividend;
  logic [W-1:0]   div_divisor;
  logic [W-1:0]   div_mult;
  mi_div_status_t div_status;
  logic [W-1:0]   div_rem;
  logic [W-1:0]   div_prod;
  logic           out_free;

  assign in_value   = operands.value[W-1:0];
  assign in_modulus = operands.modulus[W-1:0];
  assign operands.ready = (state == S_IDLE);
  assign accept     = operands.valid && (state == S_IDLE);
  assign out_free   = !out_valid || result.ready;

  assign start = (accept && (in_modulus != '0)) || ((state == S_CHECK) && (r1 != '0));
  assign div_dividend = (state == S_IDLE) ? in_value : r0;
  assign div_divisor  = (state == S_IDLE) ? in_modulus : r1;
  assign div_mult     = (state == S_IDLE) ? '0 : u1;

  mi_div_unit #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .mult      (div_mult),
    .status    (div_status),
    .remainder (div_rem),
    .product   (div_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (in_modulus == '0) ? S_OUT : S_RUN;
          end
        end
        S_RUN: begin
          if (div_status.done) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (r1 != '0) begin
            state <= S_RUN;
          end else if (r0 != W'(1)) begin
            state <= S_OUT;
          end else begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          state <= S_NEG;
        end
        S_NEG: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          m      <= in_modulus;
          r0     <= in_modulus;
          u0     <= '0;
          u1     <= W'(1);
          parity <= 1'b0;
          first  <= 1'b1;
          flag   <= (in_modulus == '0);
          x      <= '0;
        end
      end
      S_NEXT: begin
        first <= 1'b0;
        if (first) begin
          r1 <= div_rem;
        end else begin
          r0     <= r1;
          r1     <= div_rem;
          u0     <= u1;
          u1     <= div_prod + u0;
          parity <= ~parity;
        end
      end
      S_CHECK: begin
        if (r1 == '0) begin
          if (r0 != W'(1)) begin
            flag <= 1'b1;
            x    <= '0;
          end else begin
            x <= u0;
          end
        end
      end
      S_FIX: begin
        if (x >= m) begin
          x <= x - m;
        end
      end
      S_NEG: begin
        if (!parity && (x != '0)) begin
          x <= m - x;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      out_inverse     <= x;
      out_not_coprime <= flag;
    end
  end

  assign result.valid       = out_valid;
  assign result.inverse     = FIELD_BITS'(out_inverse);
  assign result.not_coprime = out_not_coprime;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for modular_inverse_core: directed table, then random operand beats.
`timescale 1ns / 1ps
module testbench;
  import mi_pkg::*;

  localparam int OPERAND_BITS = 63;
  localparam int NUM_DIRECTED = 21;
  localparam int NUM_RANDOM = 80;
  localparam int PHASE1_START = 30;
  localparam int PHASE2_START = 55;
  localparam int STALL_AT = 65;
  localparam int STALL_CYCLES = 15000;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 2 * (OPERAND_BITS + 2) + 8;
  localparam int MAX_REPORTS = 10;

  localparam logic [FIELD_BITS-1:0] MAX_OPERAND = {FIELD_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0] FIB_91 = 63'd4660046610375530309;
  localparam logic [FIELD_BITS-1:0] FIB_92 = 63'd7540113804746346429;
  localparam logic [FIELD_BITS-1:0] TOP_BIT = 63'h4000_0000_0000_0000;

  typedef struct packed {
    logic [FIELD_BITS-1:0] inverse;
    logic                  not_coprime;
  } inverse_beat_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] value;
    logic [FIELD_BITS-1:0] modulus;
    logic                  fixed_result;
    logic [FIELD_BITS-1:0] inverse;
    logic                  not_coprime;
  } directed_row_t;

  logic clk;
  logic rst;

  mi_operand_if operands_ch ();
  mi_result_if  result_ch ();

  modular_inverse_core #(
    .OPERAND_BITS(OPERAND_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_ch),
    .result   (result_ch)
  );

  inverse_beat_t pending_inverses[$];
  int unsigned   mismatches = 0;
  int unsigned   tx_idle_pct = 6;
  int unsigned   rx_idle_pct = 59;
  int unsigned   quiet_cycles = 0;
  int unsigned   stall_left = 0;
  bit            stall_request = 0;

  directed_row_t directed [NUM_DIRECTED] = '{
    '{63'd1, 63'd1, 1'b1, 63'd0, 1'b0},
    '{63'd0, 63'd1, 1'b1, 63'd0, 1'b0},
    '{MAX_OPERAND, 63'd1, 1'b1, 63'd0, 1'b0},
    '{63'd0, 63'd5, 1'b1, 63'd0, 1'b1},
    '{63'd5, 63'd0, 1'b1, 63'd0, 1'b1},
    '{63'd0, 63'd0, 1'b1, 63'd0, 1'b1},
    '{MAX_OPERAND, MAX_OPERAND, 1'b1, 63'd0, 1'b1},
    '{63'd1, MAX_OPERAND, 1'b1, 63'd1, 1'b0},
    '{63'd2, 63'd4, 1'b1, 63'd0, 1'b1},
    '{63'd1, 63'd2, 1'b1, 63'd1, 1'b0},
    '{MAX_OPERAND, 63'd2, 1'b1, 63'd1, 1'b0},
    '{63'd3, 63'd7, 1'b1, 63'd5, 1'b0},
    '{63'd6, 63'd9, 1'b1, 63'd0, 1'b1},
    '{MAX_OPERAND - 63'd1, MAX_OPERAND, 1'b1, MAX_OPERAND - 63'd1, 1'b0},
    '{63'd10, 63'd7, 1'b0, 63'd0, 1'b0},
    '{63'd2, MAX_OPERAND, 1'b0, 63'd0, 1'b0},
    '{FIB_91, FIB_92, 1'b0, 63'd0, 1'b0},
    '{FIB_92, FIB_91, 1'b0, 63'd0, 1'b0},
    '{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAB, 1'b0, 63'd0, 1'b0},
    '{TOP_BIT, MAX_OPERAND, 1'b0, 63'd0, 1'b0},
    '{MAX_OPERAND, TOP_BIT - 63'd1, 1'b0, 63'd0, 1'b0}
  };

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic inverse_beat_t inverse_of(logic [FIELD_BITS-1:0] value,
                                               logic [FIELD_BITS-1:0] modulus);
    logic [63:0]   rem_hi, rem_lo, coef_lo, coef_hi, quot, rem_next, coef_next, x;
    logic [63:0]   m;
    int unsigned   quotients;
    inverse_beat_t beat;
    beat = '0;
    m = {1'b0, modulus};
    if (m == 64'd0) begin
      beat.not_coprime = 1'b1;
      return beat;
    end
    rem_hi = m;
    rem_lo = {1'b0, value} % m;
    coef_lo = 64'd0;
    coef_hi = 64'd1;
    quotients = 0;
    while (rem_lo != 64'd0) begin
      quot = rem_hi / rem_lo;
      rem_next = rem_hi - quot * rem_lo;
      coef_next = coef_lo + quot * coef_hi;
      rem_hi = rem_lo;
      rem_lo = rem_next;
      coef_lo = coef_hi;
      coef_hi = coef_next;
      quotients++;
    end
    if (rem_hi != 64'd1) begin
      beat.not_coprime = 1'b1;
      return beat;
    end
    x = coef_lo % m;
    if (quotients[0] == 1'b0 && x != 64'd0) x = m - x;
    if (x >= m) x = x - m;
    beat.inverse = x[FIELD_BITS-1:0];
    return beat;
  endfunction

  function automatic logic [FIELD_BITS-1:0] random_operand(int unsigned width);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if (width < 64) raw = raw & ((64'd1 << width) - 64'd1);
    return raw[FIELD_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] edge_operand();
    logic [FIELD_BITS-1:0] pick;
    case ($urandom_range(4))
      0: pick = '0;
      1: pick = 63'd1;
      2: pick = 63'd2;
      3: pick = MAX_OPERAND;
      default: pick = MAX_OPERAND - 63'd1;
    endcase
    return pick;
  endfunction

  task automatic offer_operands(input logic [FIELD_BITS-1:0] value,
                                input logic [FIELD_BITS-1:0] modulus,
                                input logic fixed_result,
                                input inverse_beat_t fixed_beat);
    while ($urandom_range(99) < tx_idle_pct) begin
      operands_ch.valid <= 1'b0;
      @(posedge clk);
    end
    operands_ch.valid <= 1'b1;
    operands_ch.value <= value;
    operands_ch.modulus <= modulus;
    @(posedge clk);
    while (!operands_ch.ready) @(posedge clk);
    pending_inverses.push_back(fixed_result ? fixed_beat : inverse_of(value, modulus));
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_left = STALL_CYCLES;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((operands_ch.valid && operands_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    inverse_beat_t want;
    if (result_ch.valid && result_ch.ready) begin
      if (pending_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: inverse %0d not_coprime %0b",
                   result_ch.inverse, result_ch.not_coprime);
      end else begin
        want = pending_inverses.pop_front();
        if (result_ch.inverse !== want.inverse || result_ch.not_coprime !== want.not_coprime) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: expected inverse %0d not_coprime %0b, ",
                      "got inverse %0d not_coprime %0b"},
                     want.inverse, want.not_coprime, result_ch.inverse, result_ch.not_coprime);
        end
      end
    end
  end

  initial begin
    logic [FIELD_BITS-1:0] value, modulus;
    int unsigned           factor;
    rst = 1'b1;
    operands_ch.valid = 1'b0;
    operands_ch.value = '0;
    operands_ch.modulus = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_operands(directed[i].value, directed[i].modulus, directed[i].fixed_result,
                     '{directed[i].inverse, directed[i].not_coprime});
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == PHASE1_START) begin
        tx_idle_pct = 59;
        rx_idle_pct = 6;
      end
      if (i == PHASE2_START) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (i == STALL_AT) stall_request = 1;
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          value = random_operand(63);
          modulus = random_operand(63);
        end
        4, 5: begin
          value = random_operand($urandom_range(1, 16));
          modulus = random_operand($urandom_range(1, 16));
        end
        6: begin
          factor = $urandom_range(2, 1000);
          value = random_operand(40) * factor;
          modulus = (random_operand(40) | 63'd1) * factor;
        end
        7: begin
          value = random_operand(63);
          modulus = random_operand($urandom_range(1, 32));
        end
        8: begin
          value = random_operand($urandom_range(1, 63));
          modulus = random_operand($urandom_range(1, 63));
        end
        default: begin
          if ($urandom_range(1)) begin
            value = edge_operand();
            modulus = random_operand(63);
          end else begin
            value = random_operand(63);
            modulus = edge_operand();
          end
        end
      endcase
      offer_operands(value, modulus, 1'b0, '0);
    end
    operands_ch.valid <= 1'b0;

    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
